>>> rtl/core/rgbled_pkg.sv
package rgbled_pkg;

    // Effect numbers as reported on the effect output.
    typedef enum logic [3:0] {
        EFF_OFF       = 4'd0,
        EFF_BLUE      = 4'd1,
        EFF_GB_BLINK  = 4'd2,
        EFF_RY_BLINK  = 4'd3,
        EFF_BREATH    = 4'd4,
        EFF_RGB_CYCLE = 4'd5,
        EFF_G2B       = 4'd6,
        EFF_R2B       = 4'd7,
        EFF_RFALL     = 4'd8
    } effect_t;

    // Request kinds on the cmd field.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Host mode codes.
    localparam logic [7:0] CODE_OFF       = 8'h00;
    localparam logic [7:0] CODE_BLUE      = 8'h1b;
    localparam logic [7:0] CODE_GB_BLINK  = 8'h0c;
    localparam logic [7:0] CODE_RY_BLINK  = 8'h08;
    localparam logic [7:0] CODE_BREATH    = 8'h05;
    localparam logic [7:0] CODE_RGB_CYCLE = 8'h0b;
    localparam logic [7:0] CODE_G2B       = 8'h11;
    localparam logic [7:0] CODE_R2B       = 8'h16;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP  = 3'd4;

    localparam int unsigned TICKS_W = 10;

    localparam logic [TICKS_W-1:0] FAST_BLINK_RST = 10'd150;
    localparam logic [TICKS_W-1:0] SLOW_BLINK_RST = 10'd500;
    localparam logic [TICKS_W-1:0] CYCLE_RST      = 10'd1000;
    localparam logic [TICKS_W-1:0] FADE_STEP_RST  = 10'd30;
    localparam logic [TICKS_W-1:0] FALL_STEP_RST  = 10'd50;

    localparam logic [TICKS_W-1:0] ELAPSED_MAX  = 10'd1023;
    localparam logic [TICKS_W-1:0] BREATH_LAST  = 10'd999;
    localparam logic [TICKS_W-1:0] BREATH_HALF  = 10'd500;

    localparam logic [7:0] LEVEL_FULL = 8'd255;
    localparam logic [7:0] FADE_DEC   = 8'd25;
    localparam logic [7:0] FALL_DEC   = 8'd5;

    // floor(u * 255 / 500) = floor(u * 51 / 100), done as (u * 51 * 5243) >> 19.
    // The error of the reciprocal stays far below one step for u < 500.
    localparam int unsigned BREATH_MUL_W = 19;
    localparam logic [BREATH_MUL_W-1:0] BREATH_MUL = 19'd267393;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    function automatic logic [7:0] sub_floor(input logic [7:0] v, input logic [7:0] d);
        sub_floor = (v > d) ? (v - d) : 8'd0;
    endfunction

    function automatic logic [7:0] breath_level(input logic [TICKS_W-1:0] t);
        logic [TICKS_W-1:0]             rel;
        logic [8:0]                     u;
        logic [9+BREATH_MUL_W-1:0]      prod;
        logic [7:0]                     ramp;
        rel  = (t < BREATH_HALF) ? t : (t - BREATH_HALF);
        u    = rel[8:0];
        prod = {{BREATH_MUL_W{1'b0}}, u} * {9'd0, BREATH_MUL};
        ramp = prod[BREATH_MUL_W +: 8];
        breath_level = (t < BREATH_HALF) ? ramp : (LEVEL_FULL - ramp);
    endfunction

    function automatic rgb_t colour_of(input effect_t eff, input logic [1:0] ph,
                                       input logic [7:0] lvl, input logic [TICKS_W-1:0] t);
        rgb_t c;
        c = '0;
        case (eff)
            EFF_BLUE: c.blue = LEVEL_FULL;
            EFF_GB_BLINK: begin
                if (ph[0]) c.blue = LEVEL_FULL;
                else       c.green = LEVEL_FULL;
            end
            EFF_RY_BLINK: begin
                c.red = LEVEL_FULL;
                if (!ph[0]) c.green = LEVEL_FULL;
            end
            EFF_BREATH: c.blue = breath_level(t);
            EFF_RGB_CYCLE: begin
                if (ph == 2'd0)      c.red = LEVEL_FULL;
                else if (ph == 2'd1) c.green = LEVEL_FULL;
                else                 c.blue = LEVEL_FULL;
            end
            EFF_G2B: begin
                c.green = lvl;
                c.blue  = LEVEL_FULL - lvl;
            end
            EFF_R2B: begin
                c.red  = lvl;
                c.blue = LEVEL_FULL - lvl;
            end
            EFF_RFALL: c.red = lvl;
            default: c = '0;
        endcase
        colour_of = c;
    endfunction

endpackage

>>> rtl/core/rgb_led_effect_generator_top.sv
// RGB LED effect generator.
// Input channel (s_valid/s_ready): each request is either a tick (s_cmd 0,
// one millisecond of effect time) or a set (s_cmd 1) that selects an effect by
// host code in s_mode_code and restarts it. Unknown codes leave all state alone.
// Result channel (m_valid/m_ready): every accepted request yields exactly one
// result with the colour and the effect number after that request.
// The result is registered: it is valid in the cycle after acceptance.
// Throughput is one request per cycle while results are taken; the effect state
// update and the colour lookup, including the single breathing multiply, sit
// between the state registers and the result register.
// When the receiver stalls, the result register holds and s_ready drops until
// the result is taken; a request is accepted in the same cycle its predecessor
// leaves. The cfg_* port writes the five timing registers at any edge with
// cfg_we high; indexes above four are ignored. Writes are meant for idle time.
// Reset (aresetn low, synchronous) selects the off effect, clears time, level
// and phase, loads the default timing registers and empties the result register.
module rgb_led_effect_generator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic [7:0]                        s_mode_code,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_red,
    output logic [7:0]                        m_green,
    output logic [7:0]                        m_blue,
    output logic [3:0]                        m_effect,
    input  logic                              cfg_we,
    input  logic [rgbled_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbled_pkg::TICKS_W-1:0]    cfg_wdata
);
    import rgbled_pkg::*;

    logic [TICKS_W-1:0] fast_blink_reg, slow_blink_reg, cycle_reg, fade_step_reg, fall_step_reg;

    effect_t            effect_reg, effect_next;
    logic [TICKS_W-1:0] elapsed_reg, elapsed_next;
    logic [7:0]         level_reg, level_next;
    logic [1:0]         phase_reg, phase_next;

    logic               m_valid_reg, m_valid_next;
    rgb_t               rgb_reg, rgb_next;
    effect_t            m_effect_reg;

    logic               accept;
    logic [TICKS_W-1:0] elapsed_inc;
    logic [TICKS_W-1:0] limit;
    logic               due;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign elapsed_inc = (elapsed_reg < ELAPSED_MAX) ? (elapsed_reg + 10'd1) : elapsed_reg;

    always_comb begin
        case (effect_reg)
            EFF_GB_BLINK:  limit = fast_blink_reg;
            EFF_RY_BLINK:  limit = slow_blink_reg;
            EFF_RGB_CYCLE: limit = cycle_reg;
            EFF_G2B:       limit = fade_step_reg;
            EFF_R2B:       limit = fade_step_reg;
            EFF_RFALL:     limit = fall_step_reg;
            default:       limit = ELAPSED_MAX;
        endcase
    end

    assign due = (elapsed_inc >= limit);

    always_comb begin
        effect_next  = effect_reg;
        elapsed_next = elapsed_reg;
        level_next   = level_reg;
        phase_next   = phase_reg;
        if (s_cmd == CMD_SET) begin
            case (s_mode_code)
                CODE_OFF:       effect_next = EFF_OFF;
                CODE_BLUE:      effect_next = EFF_BLUE;
                CODE_GB_BLINK:  effect_next = EFF_GB_BLINK;
                CODE_RY_BLINK:  effect_next = EFF_RY_BLINK;
                CODE_BREATH:    effect_next = EFF_BREATH;
                CODE_RGB_CYCLE: effect_next = EFF_RGB_CYCLE;
                CODE_G2B:       effect_next = EFF_G2B;
                CODE_R2B:       effect_next = EFF_R2B;
                default:        effect_next = effect_reg;
            endcase
            if (s_mode_code == CODE_OFF || s_mode_code == CODE_BLUE ||
                s_mode_code == CODE_GB_BLINK || s_mode_code == CODE_RY_BLINK ||
                s_mode_code == CODE_BREATH || s_mode_code == CODE_RGB_CYCLE ||
                s_mode_code == CODE_G2B || s_mode_code == CODE_R2B) begin
                elapsed_next = '0;
                level_next   = LEVEL_FULL;
                phase_next   = 2'd0;
            end
        end else begin
            elapsed_next = elapsed_inc;
            case (effect_reg)
                EFF_BREATH: begin
                    elapsed_next = (elapsed_reg >= BREATH_LAST) ? '0 : (elapsed_reg + 10'd1);
                end
                EFF_GB_BLINK, EFF_RY_BLINK: begin
                    if (due) begin
                        elapsed_next = '0;
                        phase_next   = phase_reg ^ 2'd1;
                    end
                end
                EFF_RGB_CYCLE: begin
                    if (due) begin
                        elapsed_next = '0;
                        phase_next   = (phase_reg >= 2'd2) ? 2'd0 : (phase_reg + 2'd1);
                    end
                end
                EFF_G2B, EFF_R2B: begin
                    // Fade steps only happen while there is level left; the timer keeps counting.
                    if (level_reg != 8'd0 && due) begin
                        elapsed_next = '0;
                        level_next   = sub_floor(level_reg, FADE_DEC);
                    end
                end
                EFF_RFALL: begin
                    if (due) begin
                        elapsed_next = '0;
                        if (level_reg != 8'd0) level_next = sub_floor(level_reg, FALL_DEC);
                        else                   effect_next = EFF_OFF;
                    end
                end
                default: elapsed_next = elapsed_inc;
            endcase
        end
    end

    assign rgb_next     = colour_of(effect_next, phase_next, level_next, elapsed_next);
    assign m_valid_next = accept ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_blink_reg <= FAST_BLINK_RST;
            slow_blink_reg <= SLOW_BLINK_RST;
            cycle_reg      <= CYCLE_RST;
            fade_step_reg  <= FADE_STEP_RST;
            fall_step_reg  <= FALL_STEP_RST;
            effect_reg     <= EFF_OFF;
            elapsed_reg    <= '0;
            level_reg      <= 8'd0;
            phase_reg      <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FAST_BLINK: fast_blink_reg <= cfg_wdata;
                    REG_SLOW_BLINK: slow_blink_reg <= cfg_wdata;
                    REG_CYCLE:      cycle_reg      <= cfg_wdata;
                    REG_FADE_STEP:  fade_step_reg  <= cfg_wdata;
                    REG_FALL_STEP:  fall_step_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                effect_reg  <= effect_next;
                elapsed_reg <= elapsed_next;
                level_reg   <= level_next;
                phase_reg   <= phase_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rgb_reg      <= rgb_next;
            m_effect_reg <= effect_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_red    = rgb_reg.red;
    assign m_green  = rgb_reg.green;
    assign m_blue   = rgb_reg.blue;
    assign m_effect = m_effect_reg;

    // A held result must block new requests.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request accepted while result is stalled");

    // Breathing time never leaves its 1000-tick period.
    a_breath_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (effect_reg == EFF_BREATH) |-> (elapsed_reg <= BREATH_LAST))
        else $error("breathing time out of range");

    // The reported effect tracks the state after each request.
    a_effect_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_valid && (m_effect == effect_reg)))
        else $error("reported effect differs from state");

    // A tick while off stays dark.
    a_off_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_TICK && effect_reg == EFF_OFF) |=>
        (m_red == 8'd0 && m_green == 8'd0 && m_blue == 8'd0 && m_effect == EFF_OFF))
        else $error("off effect produced light");

endmodule
